// ===== src/mpsc_pkg.sv =====
// shared constants and codes for the multi-channel pressure step controller
package mpsc_pkg;

	// channel count and derived index width
	localparam int CHANNELS = 6;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// field widths
	localparam int OP_W   = 2;
	localparam int CHN_W  = 3;
	localparam int RAW_W  = 16;
	localparam int MPSI_W = 14;
	localparam int MOVE_W = 16;
	localparam int STAT_W = 4;
	localparam int CNT_W  = 8;
	localparam int TOL_W  = 10;
	localparam int CFG_W  = 10;
	localparam int CFGI_W = 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_IDLE    = 4'd0;
	localparam logic [STAT_W-1:0] ST_PSTEP   = 4'd1;
	localparam logic [STAT_W-1:0] ST_REACHED = 4'd2;
	localparam logic [STAT_W-1:0] ST_MSTEP   = 4'd3;
	localparam logic [STAT_W-1:0] ST_MDONE   = 4'd4;
	localparam logic [STAT_W-1:0] ST_TSET    = 4'd5;
	localparam logic [STAT_W-1:0] ST_MOVE    = 4'd6;
	localparam logic [STAT_W-1:0] ST_STOP    = 4'd7;
	localparam logic [STAT_W-1:0] ST_BADCH   = 4'd8;
	localparam logic [STAT_W-1:0] ST_BADTGT  = 4'd9;
	localparam logic [STAT_W-1:0] ST_ZERO    = 4'd10;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] REG_TOL   = 1'd0;
	localparam logic [CFGI_W-1:0] REG_BURST = 1'd1;

	// register reset values
	localparam logic [TOL_W-1:0] TOL_RESET   = 10'd100;
	localparam logic [CNT_W-1:0] BURST_RESET = 8'd10;

	// conversion constants
	localparam int MUL_W = 21;
	localparam int PRD_W = 2 * MUL_W;
	localparam logic [MUL_W-1:0] K_ADC    = 21'd6144;     // raw to mV, then >> 15
	localparam logic [MUL_W-1:0] K_SCALE  = 21'd150;      // 15000/4300 = 150/43
	localparam logic [MUL_W-1:0] K_RECIP  = 21'd1560672;  // ceil(2^26 / 43)
	localparam int RECIP_SH = 26;
	localparam logic [12:0] MV_MAX    = 13'd5000;
	localparam logic [12:0] MV_OFFSET = 13'd450;
	localparam logic [MPSI_W-1:0] P_MAX   = 14'd15000;
	localparam logic [MPSI_W-1:0] TGT_MIN = 14'd250;
	localparam logic [MPSI_W-1:0] TGT_MAX = 14'd12500;

endpackage

// ===== src/multi_channel_pressure_step_controller_core.sv =====
// multi-channel pressure step controller: sequencer around one shared multiplier
//
// channel  | signals                                               | handshake
// ---------+-------------------------------------------------------+---------------------
// command  | operation channel raw_sample target_mpsi move_steps   | start & !busy
//          | move_up                                               |
// result   | status channel_out pressure_mpsi direction step_count | done, one cycle
// config   | wr_index wr_data                                      | wr_en, no wait
//
// every word takes the sequencer through its busy states: three passes through the shared 21x21
// multiplier (raw to mV, scale, reciprocal divide by 43) and one decision step
// that updates channel state; the result strobe follows in the next cycle.
// a new word can be taken in the cycle the result is shown, so a word is taken only once the last is through.
// arst_n clears all channel state and restores the register reset values.
// the receiver cannot stall: each result is shown for exactly one cycle.
module multi_channel_pressure_step_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mpsc_pkg::OP_W-1:0]      operation,
	input  logic [mpsc_pkg::CHN_W-1:0]     channel,
	input  logic signed [mpsc_pkg::RAW_W-1:0] raw_sample,
	input  logic [mpsc_pkg::MPSI_W-1:0]    target_mpsi,
	input  logic [mpsc_pkg::MOVE_W-1:0]    move_steps,
	input  logic                           move_up,
	input  logic                           wr_en,
	input  logic [mpsc_pkg::CFGI_W-1:0]    wr_index,
	input  logic [mpsc_pkg::CFG_W-1:0]     wr_data,
	output logic                           done,
	output logic [mpsc_pkg::STAT_W-1:0]    status,
	output logic [mpsc_pkg::CHN_W-1:0]     channel_out,
	output logic [mpsc_pkg::MPSI_W-1:0]    pressure_mpsi,
	output logic                           direction,
	output logic [mpsc_pkg::CNT_W-1:0]     step_count
);
	import mpsc_pkg::*;

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_MUL3 = 3'd3;
	localparam logic [2:0] S_DEC  = 3'd4;

	localparam logic [CHN_W:0] CH_LIM = (CHN_W + 1)'(CHANNELS);

	logic [2:0] state_q;

	// latched command word
	logic [OP_W-1:0]   op_q;
	logic [CHN_W-1:0]  ch_q;
	logic [RAW_W-1:0]  raw_q;
	logic [MPSI_W-1:0] tgt_q;
	logic [MOVE_W-1:0] mv_q;
	logic              up_q;

	// configuration registers
	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] burst_q;

	// per-channel state
	logic [MPSI_W-1:0] target_q [CHANNELS];
	logic [MOVE_W-1:0] remain_q [CHANNELS];
	logic [CHANNELS-1:0] pmode_q;
	logic [CHANNELS-1:0] mmode_q;
	logic [CHANNELS-1:0] fwd_q;

	// shared multiplier
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;
	logic [PRD_W-1:0] prod_q;

	logic [12:0] mv_raw;
	logic [12:0] mv_clamp;
	logic [12:0] mv_ofs;
	logic [MPSI_W-1:0] quot;
	logic [MPSI_W-1:0] pres;

	assign busy = (state_q != S_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			burst_q <= BURST_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TOL:   tol_q   <= wr_data[TOL_W-1:0];
				REG_BURST: burst_q <= wr_data[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (start) state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_DEC;
				S_DEC:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= operation;
			ch_q  <= channel;
			raw_q <= raw_sample;
			tgt_q <= target_mpsi;
			mv_q  <= move_steps;
			up_q  <= move_up;
		end
	end

	// millivolts from first product, clamped, offset removed
	assign mv_raw   = prod_q[27:15];
	assign mv_clamp = (mv_raw > MV_MAX) ? MV_MAX : mv_raw;
	assign mv_ofs   = (mv_clamp > MV_OFFSET) ? (mv_clamp - MV_OFFSET) : 13'd0;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL1: begin
				mul_a = raw_q[RAW_W-1] ? '0 : MUL_W'(raw_q[RAW_W-2:0]);
				mul_b = K_ADC;
			end
			S_MUL2: begin
				mul_a = MUL_W'(mv_ofs);
				mul_b = K_SCALE;
			end
			S_MUL3: begin
				mul_a = MUL_W'(prod_q[19:0]);
				mul_b = K_RECIP;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q inside {S_MUL1, S_MUL2, S_MUL3}) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// pressure after the reciprocal divide
	assign quot = prod_q[RECIP_SH+MPSI_W-1:RECIP_SH];
	assign pres = (quot > P_MAX) ? P_MAX : quot;

	// decision on the selected channel
	logic [CH_W-1:0]   idx;
	logic              ch_ok;
	logic [CNT_W-1:0]  burst;
	logic [MPSI_W-1:0] tgt_cur;
	logic [MOVE_W-1:0] rem_cur;
	logic [MPSI_W-1:0] diff;
	logic [MOVE_W-1:0] chunk;
	logic [MOVE_W-1:0] rem_next;
	logic [STAT_W-1:0] stat_d;
	logic [MPSI_W-1:0] pres_d;
	logic              dir_d;
	logic [CNT_W-1:0]  cnt_d;

	assign idx     = ch_q[CH_W-1:0];
	assign ch_ok   = ({1'b0, ch_q} < CH_LIM);
	assign burst   = (burst_q == '0) ? CNT_W'(1) : burst_q;
	assign tgt_cur = target_q[idx];
	assign rem_cur = remain_q[idx];
	assign diff    = (pres > tgt_cur) ? (pres - tgt_cur) : (tgt_cur - pres);
	assign chunk   = (rem_cur < MOVE_W'(burst)) ? rem_cur : MOVE_W'(burst);
	assign rem_next = rem_cur - chunk;

	always_comb begin
		stat_d = ST_IDLE;
		pres_d = '0;
		dir_d  = 1'b0;
		cnt_d  = '0;
		if (op_q == OP_STOP) begin
			stat_d = ST_STOP;
		end else if (!ch_ok) begin
			stat_d = ST_BADCH;
		end else begin
			case (op_q)
				OP_SAMPLE: begin
					pres_d = pres;
					if (pmode_q[idx]) begin
						if (diff <= MPSI_W'(tol_q)) begin
							stat_d = ST_REACHED;
						end else begin
							stat_d = ST_PSTEP;
							dir_d  = (pres < tgt_cur);
							cnt_d  = burst;
						end
					end else if (mmode_q[idx] && rem_cur != '0) begin
						dir_d  = fwd_q[idx];
						cnt_d  = chunk[CNT_W-1:0];
						stat_d = (rem_next == '0) ? ST_MDONE : ST_MSTEP;
					end
				end
				OP_TARGET: begin
					stat_d = (tgt_q inside {[TGT_MIN:TGT_MAX]}) ? ST_TSET : ST_BADTGT;
				end
				OP_MOVE: begin
					if (mv_q == '0) begin
						stat_d = ST_ZERO;
					end else begin
						stat_d = ST_MOVE;
						dir_d  = up_q;
					end
				end
				default: ;
			endcase
		end
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode_q <= '0;
			mmode_q <= '0;
			fwd_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i] <= '0;
				remain_q[i] <= '0;
			end
		end else if (state_q == S_DEC) begin
			case (stat_d)
				ST_STOP: begin
					pmode_q <= '0;
					mmode_q <= '0;
					fwd_q   <= '0;
					for (int i = 0; i < CHANNELS; i++) begin
						target_q[i] <= '0;
						remain_q[i] <= '0;
					end
				end
				ST_REACHED: pmode_q[idx] <= 1'b0;
				ST_MSTEP:   remain_q[idx] <= rem_next;
				ST_MDONE: begin
					remain_q[idx] <= rem_next;
					mmode_q[idx]  <= 1'b0;
				end
				ST_TSET: begin
					target_q[idx] <= tgt_q;
					pmode_q[idx]  <= 1'b1;
					mmode_q[idx]  <= 1'b0;
					remain_q[idx] <= '0;
				end
				ST_MOVE: begin
					remain_q[idx] <= mv_q;
					fwd_q[idx]    <= up_q;
					mmode_q[idx]  <= 1'b1;
					pmode_q[idx]  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// result word register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_DEC);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC) begin
			status        <= stat_d;
			channel_out   <= (op_q == OP_STOP) ? '0 : ch_q;
			pressure_mpsi <= pres_d;
			direction     <= dir_d;
			step_count    <= cnt_d;
		end
	end

	// checks
	a_done_after_dec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DEC)
		else $error("result strobe without a decision cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_MUL1)
		else $error("accepted word did not start the sequence");

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(pmode_q & mmode_q) == '0)
		else $error("channel in pressure and manual mode at once");

	a_steps_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && step_count != '0 |->
			status == ST_PSTEP || status == ST_MSTEP || status == ST_MDONE)
		else $error("steps issued with a non-stepping status");

endmodule
